[hdl/ndf_pkg.sv]
package ndf_pkg;

  localparam int unsigned CHAR_W    = 16;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_LEN_DEFAULT   = 4096;
  localparam int unsigned DEPTH_MAX_DEFAULT = 255;

  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE_A   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE_B   = 2'd2;

  localparam logic [CHAR_W-1:0] DELIMITER_RESET = 16'd44;
  localparam logic [CHAR_W-1:0] QUOTE_A_RESET   = 16'd34;
  localparam logic [CHAR_W-1:0] QUOTE_B_RESET   = 16'd39;

  localparam logic [CHAR_W-1:0] CH_ROUND_OPEN   = 16'h0028;
  localparam logic [CHAR_W-1:0] CH_ROUND_CLOSE  = 16'h0029;
  localparam logic [CHAR_W-1:0] CH_SQUARE_OPEN  = 16'h005B;
  localparam logic [CHAR_W-1:0] CH_SQUARE_CLOSE = 16'h005D;
  localparam logic [CHAR_W-1:0] CH_CURLY_OPEN   = 16'h007B;
  localparam logic [CHAR_W-1:0] CH_CURLY_CLOSE  = 16'h007D;

  typedef struct packed {
    logic [CHAR_W-1:0] delimiter_char;
    logic [CHAR_W-1:0] quote_char_a;
    logic [CHAR_W-1:0] quote_char_b;
  } cfg_t;

  typedef struct packed {
    logic             emit;
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

[hdl/nesting_aware_delimiter_finder.sv]
// Finds the first delimiter character that lies outside quoted text and at zero round,
// square and curly bracket depth, one character word per clock. A character is taken
// into an input register, then scanned against the bracket and quote state once the
// output register can take it, and its result (if any) lands in the output register.
// One character can be accepted every cycle while in_stall is low; in_stall rises only
// when the character register is full and the output register holds a result that the
// receiver is stalling. Each string gives exactly one result word: the found position
// or not found at the character marked last_char.
module nesting_aware_delimiter_finder #(
  parameter int unsigned MAX_LEN   = ndf_pkg::MAX_LEN_DEFAULT,
  parameter int unsigned DEPTH_MAX = ndf_pkg::DEPTH_MAX_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ndf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ndf_pkg::CHAR_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ndf_pkg::CHAR_W-1:0]    char_code,
  input  logic                          last_char,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [ndf_pkg::POS_W-1:0]     position
);
  import ndf_pkg::*;

  cfg_t              cfg;
  result_t           result;
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_last;
  logic              s1_fire;
  logic              in_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_char <= DELIMITER_RESET;
      cfg.quote_char_a   <= QUOTE_A_RESET;
      cfg.quote_char_b   <= QUOTE_B_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DELIMITER: cfg.delimiter_char <= cfg_data;
        REG_QUOTE_A:   cfg.quote_char_a   <= cfg_data;
        REG_QUOTE_B:   cfg.quote_char_b   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_fire   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_char <= char_code;
      s1_last <= last_char;
    end
  end

  ndf_scan #(
    .MAX_LEN   (MAX_LEN),
    .DEPTH_MAX (DEPTH_MAX)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_fire),
    .char_code (s1_char),
    .last_char (s1_last),
    .cfg       (cfg),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= result.emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && result.emit) begin
      found    <= result.found;
      position <= result.position;
    end
  end

endmodule

[hdl/ndf_scan.sv]
module ndf_scan #(
  parameter int unsigned MAX_LEN   = ndf_pkg::MAX_LEN_DEFAULT,
  parameter int unsigned DEPTH_MAX = ndf_pkg::DEPTH_MAX_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [ndf_pkg::CHAR_W-1:0]  char_code,
  input  logic                        last_char,
  input  ndf_pkg::cfg_t               cfg,
  output ndf_pkg::result_t            result
);
  import ndf_pkg::*;

  localparam int unsigned DW = $clog2(DEPTH_MAX + 1);
  localparam int unsigned IW = $clog2(MAX_LEN + 1);
  localparam logic [DW-1:0] DMAX = DW'(DEPTH_MAX);

  logic [DW-1:0]     round_depth, round_depth_next;
  logic [DW-1:0]     square_depth, square_depth_next;
  logic [DW-1:0]     curly_depth, curly_depth_next;
  logic              in_quote, in_quote_next;
  logic              close_pending, close_pending_next;
  logic [CHAR_W-1:0] open_quote, open_quote_next;
  logic [IW-1:0]     char_index, char_index_next;
  logic              answered, answered_next;

  logic                active, check, hit;
  logic [POS_W+IW-1:0] pos_ext;

  function automatic logic [DW-1:0] depth_up(input logic [DW-1:0] d);
    depth_up = (d >= DMAX) ? DMAX : d + DW'(1);
  endfunction

  function automatic logic [DW-1:0] depth_down(input logic [DW-1:0] d);
    depth_down = (d != '0) ? d - DW'(1) : '0;
  endfunction

  always_comb begin
    round_depth_next   = round_depth;
    square_depth_next  = square_depth;
    curly_depth_next   = curly_depth;
    in_quote_next      = in_quote;
    close_pending_next = close_pending;
    open_quote_next    = open_quote;
    char_index_next    = char_index;
    answered_next      = answered;
    check              = 1'b0;
    hit                = 1'b0;

    active = !answered && (char_index < IW'(MAX_LEN));

    if (active) begin
      if (in_quote) begin
        if (close_pending) begin
          close_pending_next = 1'b0;
          if (char_code != open_quote) begin
            in_quote_next = 1'b0;
            check         = 1'b1;
          end
        end else if (char_code == open_quote) begin
          close_pending_next = 1'b1;
        end
      end else if (char_code == cfg.quote_char_a || char_code == cfg.quote_char_b) begin
        in_quote_next   = 1'b1;
        open_quote_next = char_code;
      end else begin
        check = 1'b1;
      end
      char_index_next = char_index + IW'(1);
    end

    if (check) begin
      case (char_code)
        CH_ROUND_OPEN:   round_depth_next  = depth_up(round_depth);
        CH_ROUND_CLOSE:  round_depth_next  = depth_down(round_depth);
        CH_SQUARE_OPEN:  square_depth_next = depth_up(square_depth);
        CH_SQUARE_CLOSE: square_depth_next = depth_down(square_depth);
        CH_CURLY_OPEN:   curly_depth_next  = depth_up(curly_depth);
        CH_CURLY_CLOSE:  curly_depth_next  = depth_down(curly_depth);
        default: ;
      endcase
      hit = (round_depth_next == '0) && (square_depth_next == '0) &&
            (curly_depth_next == '0) && (char_code == cfg.delimiter_char);
    end

    if (hit) begin
      answered_next = 1'b1;
    end

    pos_ext         = {{POS_W{1'b0}}, char_index};
    result.emit     = hit || (last_char && !answered);
    result.found    = hit;
    result.position = hit ? pos_ext[POS_W-1:0] : '0;

    // end of string returns all per-string state to zero
    if (last_char) begin
      round_depth_next   = '0;
      square_depth_next  = '0;
      curly_depth_next   = '0;
      in_quote_next      = 1'b0;
      close_pending_next = 1'b0;
      open_quote_next    = '0;
      char_index_next    = '0;
      answered_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_depth   <= '0;
      square_depth  <= '0;
      curly_depth   <= '0;
      in_quote      <= 1'b0;
      close_pending <= 1'b0;
      open_quote    <= '0;
      char_index    <= '0;
      answered      <= 1'b0;
    end else if (step) begin
      round_depth   <= round_depth_next;
      square_depth  <= square_depth_next;
      curly_depth   <= curly_depth_next;
      in_quote      <= in_quote_next;
      close_pending <= close_pending_next;
      open_quote    <= open_quote_next;
      char_index    <= char_index_next;
      answered      <= answered_next;
    end
  end

endmodule

[verif/delimiter_result_checker.sv]
module delimiter_result_checker
  import ndf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHAR_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic                 last_char,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 found,
  input  logic [POS_W-1:0]     position,
  output int                   errors,
  output int                   waiting,
  output int                   found_seen,
  output int                   missed_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } answer_t;

  answer_t answers_q[$];

  logic [CHAR_W-1:0] delim_r;
  logic [CHAR_W-1:0] quote_a_r;
  logic [CHAR_W-1:0] quote_b_r;
  logic [CHAR_W-1:0] opener;
  int                round_lvl;
  int                square_lvl;
  int                curly_lvl;
  int                char_pos;
  logic              quoted;
  logic              close_wait;
  logic              answered;

  function automatic int nest_up(input int d);
    return (d >= int'(DEPTH_MAX_DEFAULT)) ? int'(DEPTH_MAX_DEFAULT) : d + 1;
  endfunction

  function automatic int nest_down(input int d);
    return (d > 0) ? d - 1 : 0;
  endfunction

  // brackets move first, then the delimiter test at zero depth
  function automatic logic bracket_then_match(input logic [CHAR_W-1:0] c);
    case (c)
      CH_ROUND_OPEN:   round_lvl  = nest_up(round_lvl);
      CH_ROUND_CLOSE:  round_lvl  = nest_down(round_lvl);
      CH_SQUARE_OPEN:  square_lvl = nest_up(square_lvl);
      CH_SQUARE_CLOSE: square_lvl = nest_down(square_lvl);
      CH_CURLY_OPEN:   curly_lvl  = nest_up(curly_lvl);
      CH_CURLY_CLOSE:  curly_lvl  = nest_down(curly_lvl);
      default: ;
    endcase
    return round_lvl == 0 && square_lvl == 0 && curly_lvl == 0 && c == delim_r;
  endfunction

  task automatic clear_string();
    round_lvl  = 0;
    square_lvl = 0;
    curly_lvl  = 0;
    quoted     = 1'b0;
    close_wait = 1'b0;
    opener     = '0;
    char_pos   = 0;
    answered   = 1'b0;
  endtask

  task automatic scan_char(input logic [CHAR_W-1:0] c, input logic last);
    logic    hit;
    answer_t a;
    hit        = 1'b0;
    a.found    = 1'b0;
    a.position = char_pos[POS_W-1:0];
    if (!answered && char_pos < int'(MAX_LEN_DEFAULT)) begin
      if (quoted) begin
        if (close_wait) begin
          close_wait = 1'b0;
          // a doubled quote stays inside; anything else closes and is checked
          if (c != opener) begin
            quoted = 1'b0;
            hit    = bracket_then_match(c);
          end
        end else if (c == opener) begin
          close_wait = 1'b1;
        end
      end else if (c == quote_a_r || c == quote_b_r) begin
        quoted = 1'b1;
        opener = c;
      end else begin
        hit = bracket_then_match(c);
      end
      char_pos++;
    end
    if (hit) begin
      a.found  = 1'b1;
      answered = 1'b1;
      answers_q.push_back(a);
    end else if (last && !answered) begin
      a.position = '0;
      answers_q.push_back(a);
    end
    if (last) clear_string();
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      delim_r   = DELIMITER_RESET;
      quote_a_r = QUOTE_A_RESET;
      quote_b_r = QUOTE_B_RESET;
      clear_string();
      answers_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_q.size() == 0) begin
          $error("result word with nothing expected: found=%0d position=%0d", found, position);
          errors++;
        end else begin
          want = answers_q.pop_front();
          if (found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, found);
            errors++;
          end
          if (position !== want.position) begin
            $error("position mismatch: expected %0d, actual %0d", want.position, position);
            errors++;
          end
          if (want.found) found_seen++;
          else missed_seen++;
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_DELIMITER: delim_r   = cfg_data;
          REG_QUOTE_A:   quote_a_r = cfg_data;
          REG_QUOTE_B:   quote_b_r = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) scan_char(char_code, last_char);
    end
    waiting <= answers_q.size();
  end

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ndf_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int WORDS_PER_SET = 160;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DELIMITER;
  logic [CHAR_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [CHAR_W-1:0]    char_code = '0;
  logic                 last_char = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 found;
  logic [POS_W-1:0]     position;

  int errors;
  int waiting;
  int found_seen;
  int missed_seen;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int strings_sent   = 0;
  int settings_used  = 1;

  logic [CHAR_W-1:0] cur_delim = DELIMITER_RESET;
  logic [CHAR_W-1:0] cur_qa    = QUOTE_A_RESET;
  logic [CHAR_W-1:0] cur_qb    = QUOTE_B_RESET;
  logic [CHAR_W-1:0] line_q[$];

  nesting_aware_delimiter_finder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .position  (position)
  );

  delimiter_result_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .last_char   (last_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .position    (position),
    .errors      (errors),
    .waiting     (waiting),
    .found_seen  (found_seen),
    .missed_seen (missed_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] letter();
    return CHAR_W'(16'h0061 + $urandom_range(25));
  endfunction

  function automatic logic [CHAR_W-1:0] any_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) return cur_delim;
    if (pick < 30) return cur_qa;
    if (pick < 38) return cur_qb;
    if (pick < 44) return CH_ROUND_OPEN;
    if (pick < 50) return CH_ROUND_CLOSE;
    if (pick < 54) return CH_SQUARE_OPEN;
    if (pick < 58) return CH_SQUARE_CLOSE;
    if (pick < 62) return CH_CURLY_OPEN;
    if (pick < 66) return CH_CURLY_CLOSE;
    if (pick < 90) return letter();
    return CHAR_W'($urandom_range(65535));
  endfunction

  // quoted text, sometimes with doubled quotes inside
  task automatic add_quoted();
    logic [CHAR_W-1:0] q;
    q = $urandom_range(1) ? cur_qa : cur_qb;
    line_q.push_back(q);
    repeat ($urandom_range(3)) begin
      case ($urandom_range(2))
        0: line_q.push_back(letter());
        1: begin
          line_q.push_back(q);
          line_q.push_back(q);
        end
        default: line_q.push_back(cur_delim);
      endcase
    end
    line_q.push_back(q);
  endtask

  task automatic add_group(input bit nest);
    logic [CHAR_W-1:0] opn;
    logic [CHAR_W-1:0] cls;
    case ($urandom_range(2))
      0: begin
        opn = CH_ROUND_OPEN;
        cls = CH_ROUND_CLOSE;
      end
      1: begin
        opn = CH_SQUARE_OPEN;
        cls = CH_SQUARE_CLOSE;
      end
      default: begin
        opn = CH_CURLY_OPEN;
        cls = CH_CURLY_CLOSE;
      end
    endcase
    line_q.push_back(opn);
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(nest ? 3 : 2))
        0: line_q.push_back(letter());
        1: line_q.push_back(cur_delim);
        2: add_quoted();
        default: add_group(1'b0);
      endcase
    end
    line_q.push_back(cls);
  endtask

  // mostly balanced strings with random content, the rest noise or damaged
  task automatic build_line();
    int len;
    line_q.delete();
    if ($urandom_range(99) < 65) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(3))
          0: repeat ($urandom_range(1, 3)) line_q.push_back(letter());
          1: line_q.push_back(cur_delim);
          2: add_quoted();
          default: add_group(1'b1);
        endcase
      end
      if ($urandom_range(99) < 15) begin
        line_q.insert($urandom_range(line_q.size()), any_char());
      end else if ($urandom_range(99) < 10) begin
        void'(line_q.pop_back());
      end
    end else begin
      len = ($urandom_range(99) < 5) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      repeat (len) line_q.push_back(any_char());
    end
    if (line_q.size() == 0) line_q.push_back(letter());
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) begin
      if ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
      end
      in_valid  <= 1'b1;
      char_code <= line_q[i];
      last_char <= (i == line_q.size() - 1);
      do @(posedge clk); while (in_stall);
    end
    strings_sent++;
  endtask

  task automatic send_text(input string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) line_q.push_back(CHAR_W'(s[i]));
    send_line();
  endtask

  // open n brackets, close DEPTH_MAX of them, then a delimiter
  task automatic send_saturating(input logic [CHAR_W-1:0] opn, input logic [CHAR_W-1:0] cls,
                                 input int n);
    line_q.delete();
    repeat (n) line_q.push_back(opn);
    repeat (DEPTH_MAX_DEFAULT) line_q.push_back(cls);
    line_q.push_back(cur_delim);
    send_line();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      while (waiting != 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end while (waiting != 0);
  endtask

  task automatic run_random(input int words);
    int sent;
    sent = 0;
    while (sent < words) begin
      build_line();
      sent += line_q.size();
      send_line();
      if ($urandom_range(99) < 3) drain();
    end
  endtask

  task automatic set_config(input logic [CHAR_W-1:0] d, input logic [CHAR_W-1:0] a,
                            input logic [CHAR_W-1:0] b);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_DELIMITER;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= REG_QUOTE_A;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= REG_QUOTE_B;
    cfg_data  <= b;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_delim = d;
    cur_qa    = a;
    cur_qb    = b;
    settings_used++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 33;
    recv_idle_pct = 80;
    send_text("a,b");
    send_text("(,),");
    send_text("\"a\"\",\",");
    send_text("'x");
    send_text("\"x\"");
    send_text("]},");
    send_text("\"a\"',");
    run_random(WORDS_PER_SET);
    set_config(16'hFFFF, 16'h0000, 16'hFFFE);
    run_random(WORDS_PER_SET);

    send_idle_pct = 80;
    recv_idle_pct = 33;
    set_config(QUOTE_A_RESET, QUOTE_A_RESET, QUOTE_B_RESET);
    run_random(WORDS_PER_SET);
    set_config(CH_ROUND_CLOSE, 16'h0060, 16'h007C);
    run_random(WORDS_PER_SET);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(CH_ROUND_OPEN, 16'hFFFF, 16'h0000);
    run_random(WORDS_PER_SET);
    set_config(16'h0000, CH_SQUARE_OPEN, QUOTE_A_RESET);
    run_random(WORDS_PER_SET);

    set_config(DELIMITER_RESET, QUOTE_A_RESET, QUOTE_B_RESET);
    send_saturating(CH_ROUND_OPEN, CH_ROUND_CLOSE, 256);
    run_random(60);

    drain();
    repeat (8) @(posedge clk);
    $display("Scanned %0d strings under %0d register settings, incl. a saturating bracket run",
             strings_sent, settings_used);
    $display("Result words checked: %0d found, %0d not found", found_seen, missed_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
